[design/atcmd_pkg.sv]
// Package for the AT command line recogniser: sizes, character constants,
// command codes, sequencer states and the structs passed between modules.
// No dependencies.
`default_nettype none

package atcmd_pkg;

    localparam int LINE_CAPACITY = 16;
    localparam int STORE_DEPTH   = LINE_CAPACITY - 1;
    localparam int LEN_W         = $clog2(LINE_CAPACITY);
    localparam int ADDR_W        = $clog2(STORE_DEPTH);
    localparam int OFS_W         = 3;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LC    = 8'h63;
    localparam logic [7:0] CH_LH    = 8'h68;
    localparam logic [7:0] CH_LQ    = 8'h71;
    localparam logic [7:0] CH_LR    = 8'h72;
    localparam logic [7:0] CH_LS    = 8'h73;
    localparam logic [7:0] CH_LT    = 8'h74;

    localparam logic [OFS_W-1:0] OFS_A      = 3'd0;
    localparam logic [OFS_W-1:0] OFS_T      = 3'd1;
    localparam logic [OFS_W-1:0] OFS_PLUS   = 3'd2;
    localparam logic [OFS_W-1:0] OFS_LETTER = 3'd3;
    localparam logic [OFS_W-1:0] OFS_TAIL   = 3'd4;

    localparam logic [2:0] CODE_HELP   = 3'd0;
    localparam logic [2:0] CODE_RUN    = 3'd1;
    localparam logic [2:0] CODE_CHECK  = 3'd2;
    localparam logic [2:0] CODE_SIGN   = 3'd3;
    localparam logic [2:0] CODE_QUIT   = 3'd4;
    localparam logic [2:0] CODE_REJECT = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic       is_space;
        logic       hit;
        logic [2:0] code;
    } t_cmp_res;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_UA && c <= CH_UZ) begin
            r = c + 8'd32;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[design/atcmd_stream_if.sv]
// Valid/ready channel interfaces for the character input and the command output.
// Depends on nothing.
`default_nettype none

interface atcmd_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink (input valid, input char_in, output ready);
endinterface

interface atcmd_code_if;
    logic       valid;
    logic       ready;
    logic [2:0] command_code;

    modport source (output valid, output command_code, input ready);
    modport sink (input valid, input command_code, output ready);
endinterface

`default_nettype wire

[design/atcmd_line_mem.sv]
// Line store: one write port and one registered read port.
// Depends on atcmd_pkg.
`default_nettype none

module atcmd_line_mem (
    input  wire logic                i_clk,
    input  wire atcmd_pkg::t_mem_req i_req,
    output logic [7:0]               o_rdata
);

    logic [7:0] r_mem [atcmd_pkg::STORE_DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[design/atcmd_char_cmp.sv]
// Shared character compare unit: checks one stored byte against the pattern
// position reached so far. Depends on atcmd_pkg.
`default_nettype none

module atcmd_char_cmp (
    input  wire logic [7:0]                  i_char,
    input  wire logic [atcmd_pkg::OFS_W-1:0] i_ofs,
    output atcmd_pkg::t_cmp_res              o_res
);

    logic [7:0] w_low;

    always_comb begin
        w_low          = atcmd_pkg::to_lower(i_char);
        o_res.is_space = (i_char == atcmd_pkg::CH_SPACE);
        o_res.hit      = 1'b0;
        o_res.code     = atcmd_pkg::CODE_REJECT;
        case (i_ofs)
            atcmd_pkg::OFS_A: begin
                o_res.hit = (w_low == atcmd_pkg::CH_LA);
            end
            atcmd_pkg::OFS_T: begin
                o_res.hit = (w_low == atcmd_pkg::CH_LT);
            end
            atcmd_pkg::OFS_PLUS: begin
                o_res.hit = (i_char == atcmd_pkg::CH_PLUS);
            end
            atcmd_pkg::OFS_LETTER: begin
                o_res.hit = 1'b1;
                case (w_low)
                    atcmd_pkg::CH_LH: o_res.code = atcmd_pkg::CODE_HELP;
                    atcmd_pkg::CH_LR: o_res.code = atcmd_pkg::CODE_RUN;
                    atcmd_pkg::CH_LC: o_res.code = atcmd_pkg::CODE_CHECK;
                    atcmd_pkg::CH_LS: o_res.code = atcmd_pkg::CODE_SIGN;
                    atcmd_pkg::CH_LQ: o_res.code = atcmd_pkg::CODE_QUIT;
                    default: o_res.hit = 1'b0;
                endcase
            end
            atcmd_pkg::OFS_TAIL: begin
                o_res.hit = o_res.is_space;
            end
            default: o_res.hit = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

[design/at_command_line_recognizer_unit.sv]
// AT command line recogniser top level: sequencer, line length and output register.
// Depends on atcmd_pkg, atcmd_stream_if, atcmd_line_mem and atcmd_char_cmp.
//
// Characters arrive on i_char, one per transfer, and command codes leave on
// o_code (0 help, 1 run, 2 check, 3 sign, 4 quit, 5 rejected line).
// A character that is stored, or a line end on a non-empty line, starts a
// scan of the stored line: one entry is read from the line store per cycle
// and checked by the shared compare unit, and i_char is not ready until the
// sequencer is back in ST_IDLE. Erase and empty line ends are handled in
// ST_IDLE without a scan; a full-line reject goes straight to ST_FINISH.
// A result sits in an output register; the next character is taken while it
// waits. If a new result is due while the previous one has not been taken,
// the sequencer holds until o_code is free.
// Reset empties the line and drops any pending result; the line store needs
// no clearing, as only entries written since the line was started are read.
`default_nettype none

module at_command_line_recognizer_unit (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    atcmd_char_if.sink  i_char,
    atcmd_code_if.source o_code
);

    atcmd_pkg::t_state              r_state, n_state;
    logic [atcmd_pkg::LEN_W-1:0]    r_len, n_len;
    logic [atcmd_pkg::LEN_W-1:0]    r_idx, n_idx;
    logic                           r_rd_vld, n_rd_vld;
    logic [atcmd_pkg::OFS_W-1:0]    r_ofs, n_ofs;
    logic                           r_fail, n_fail;
    logic                           r_eol, n_eol;
    logic [2:0]                     r_letter, n_letter;
    logic                           r_out_vld, n_out_vld;
    logic [2:0]                     r_out_code, n_out_code;

    atcmd_pkg::t_mem_req            w_mem_req;
    logic [7:0]                     w_rdata;
    atcmd_pkg::t_cmp_res            w_cmp;
    logic                           w_accept;
    logic                           w_out_free;
    logic                           w_is_eol;
    logic                           w_is_erase;

    atcmd_line_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (w_mem_req),
        .o_rdata (w_rdata)
    );

    atcmd_char_cmp u_cmp (
        .i_char (w_rdata),
        .i_ofs  (r_ofs),
        .o_res  (w_cmp)
    );

    assign i_char.ready        = (r_state == atcmd_pkg::ST_IDLE);
    assign w_accept            = i_char.valid && i_char.ready;
    assign o_code.valid        = r_out_vld;
    assign o_code.command_code = r_out_code;
    assign w_out_free          = !r_out_vld || o_code.ready;
    assign w_is_eol   = (i_char.char_in == atcmd_pkg::CH_CR) ||
                        (i_char.char_in == atcmd_pkg::CH_LF);
    assign w_is_erase = (i_char.char_in == atcmd_pkg::CH_BS) ||
                        (i_char.char_in == atcmd_pkg::CH_DEL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= atcmd_pkg::ST_IDLE;
            r_len     <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_len     <= n_len;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
        r_idx      <= n_idx;
        r_ofs      <= n_ofs;
        r_fail     <= n_fail;
        r_eol      <= n_eol;
        r_letter   <= n_letter;
        r_out_code <= n_out_code;
    end

    always_comb begin
        n_state    = r_state;
        n_len      = r_len;
        n_idx      = r_idx;
        n_rd_vld   = 1'b0;
        n_ofs      = r_ofs;
        n_fail     = r_fail;
        n_eol      = r_eol;
        n_letter   = r_letter;
        n_out_vld  = r_out_vld && !o_code.ready;
        n_out_code = r_out_code;

        w_mem_req.we    = 1'b0;
        w_mem_req.waddr = r_len[atcmd_pkg::ADDR_W-1:0];
        w_mem_req.wdata = i_char.char_in;
        w_mem_req.raddr = r_idx[atcmd_pkg::ADDR_W-1:0];

        case (r_state)
            atcmd_pkg::ST_IDLE: begin
                n_idx  = '0;
                n_ofs  = atcmd_pkg::OFS_A;
                n_fail = 1'b0;
                if (w_accept) begin
                    if (w_is_eol) begin
                        if (r_len != '0) begin
                            n_eol   = 1'b1;
                            n_state = atcmd_pkg::ST_SCAN;
                        end
                    end else if (w_is_erase && r_len != '0) begin
                        n_len = r_len - 1'b1;
                    end else if (r_len >= atcmd_pkg::LEN_W'(atcmd_pkg::STORE_DEPTH)) begin
                        n_eol   = 1'b1;
                        n_fail  = 1'b1;
                        n_state = atcmd_pkg::ST_FINISH;
                    end else begin
                        w_mem_req.we = 1'b1;
                        n_len        = r_len + 1'b1;
                        n_eol        = 1'b0;
                        n_state      = atcmd_pkg::ST_SCAN;
                    end
                end
            end
            atcmd_pkg::ST_SCAN: begin
                if (r_idx != r_len) begin
                    n_idx    = r_idx + 1'b1;
                    n_rd_vld = 1'b1;
                end else if (!r_rd_vld) begin
                    n_state = atcmd_pkg::ST_FINISH;
                end
                if (r_rd_vld && !r_fail) begin
                    if (r_ofs == atcmd_pkg::OFS_A && w_cmp.is_space) begin
                        n_ofs = r_ofs;
                    end else if (!w_cmp.hit) begin
                        n_fail = 1'b1;
                    end else if (r_ofs != atcmd_pkg::OFS_TAIL) begin
                        if (r_ofs == atcmd_pkg::OFS_LETTER) begin
                            n_letter = w_cmp.code;
                        end
                        n_ofs = r_ofs + 1'b1;
                    end
                end
            end
            atcmd_pkg::ST_FINISH: begin
                if (!r_fail && r_ofs == atcmd_pkg::OFS_TAIL) begin
                    if (w_out_free) begin
                        n_out_vld  = 1'b1;
                        n_out_code = r_letter;
                        n_len      = '0;
                        n_state    = atcmd_pkg::ST_IDLE;
                    end
                end else if (r_eol) begin
                    if (w_out_free) begin
                        n_out_vld  = 1'b1;
                        n_out_code = atcmd_pkg::CODE_REJECT;
                        n_len      = '0;
                        n_state    = atcmd_pkg::ST_IDLE;
                    end
                end else begin
                    n_state = atcmd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = atcmd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[tb/at_command_line_recognizer_unit_tb.sv]
// Self-checking testbench for at_command_line_recognizer_unit: directed table, then random
// command lines, noise and overflows, each result checked against the table or a line predictor.
// Depends on atcmd_pkg, atcmd_stream_if and the recogniser RTL.
`default_nettype none

module at_command_line_recognizer_unit_tb;

    localparam int CLK_HALF    = 6;
    localparam int ITEM_TARGET = 1300;
    localparam int IDLE_LIMIT  = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 40;
    localparam int N_DIRECTED  = 36;

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_NO_RESULT,
        ROW_GIVES
    } t_row_kind;

    typedef struct packed {
        logic [7:0] ch;
        logic [4:0] count;
        t_row_kind  kind;
        logic [2:0] code;
    } t_stim_row;

    typedef struct packed {
        t_row_kind  kind;
        logic [2:0] code;
    } t_item_tag;

    logic i_clk;
    logic i_rst_n;

    atcmd_char_if char_ch();
    atcmd_code_if code_ch();

    at_command_line_recognizer_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_ch),
        .o_code  (code_ch)
    );

    logic [7:0]  line_copy [atcmd_pkg::STORE_DEPTH];
    int unsigned line_len = 0;

    t_item_tag   char_tag_q [$];
    logic [2:0]  code_expect_q [$];
    logic [7:0]  sentence_q [$];
    t_stim_row   directed_rows [N_DIRECTED];

    int unsigned error_count     = 0;
    int unsigned chars_counted   = 0;
    int unsigned codes_checked   = 0;
    int unsigned rejects_checked = 0;
    int unsigned idle_cycles     = 0;
    bit          hold_req        = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        return (c >= atcmd_pkg::CH_UA && c <= atcmd_pkg::CH_UZ) ? (c | 8'h20) : c;
    endfunction

    function automatic bit match_line(output logic [2:0] code);
        int lo;
        int hi;
        logic [7:0] letter;
        lo = 0;
        hi = int'(line_len);
        code = atcmd_pkg::CODE_REJECT;
        while (lo < hi && line_copy[lo] == atcmd_pkg::CH_SPACE) lo++;
        while (hi > lo && line_copy[hi-1] == atcmd_pkg::CH_SPACE) hi--;
        if (hi - lo != 4) return 1'b0;
        if (fold_case(line_copy[lo]) != atcmd_pkg::CH_LA ||
            fold_case(line_copy[lo+1]) != atcmd_pkg::CH_LT ||
            line_copy[lo+2] != atcmd_pkg::CH_PLUS) return 1'b0;
        letter = fold_case(line_copy[lo+3]);
        case (letter)
            atcmd_pkg::CH_LH: code = atcmd_pkg::CODE_HELP;
            atcmd_pkg::CH_LR: code = atcmd_pkg::CODE_RUN;
            atcmd_pkg::CH_LC: code = atcmd_pkg::CODE_CHECK;
            atcmd_pkg::CH_LS: code = atcmd_pkg::CODE_SIGN;
            atcmd_pkg::CH_LQ: code = atcmd_pkg::CODE_QUIT;
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    // Advances the line copy by one character and gives the command code it causes.
    function automatic void take_char(input logic [7:0] c, output bit gives,
                                      output logic [2:0] code, output bit ignored);
        gives = 1'b0;
        ignored = 1'b0;
        code = atcmd_pkg::CODE_REJECT;
        if (c == atcmd_pkg::CH_CR || c == atcmd_pkg::CH_LF) begin
            if (line_len == 0) begin
                ignored = 1'b1;
            end else begin
                gives = 1'b1;
                if (!match_line(code)) code = atcmd_pkg::CODE_REJECT;
                line_len = 0;
            end
        end else if ((c == atcmd_pkg::CH_BS || c == atcmd_pkg::CH_DEL) && line_len > 0) begin
            line_len--;
        end else if (line_len >= atcmd_pkg::STORE_DEPTH) begin
            gives = 1'b1;
            line_len = 0;
        end else begin
            line_copy[line_len] = c;
            line_len++;
            if (match_line(code)) begin
                gives = 1'b1;
                line_len = 0;
            end
        end
    endfunction

    function automatic t_stim_row row_quiet(input logic [7:0] ch, input int n);
        return '{ch, 5'(n), ROW_NO_RESULT, atcmd_pkg::CODE_REJECT};
    endfunction

    function automatic t_stim_row row_pred(input logic [7:0] ch);
        return '{ch, 5'd1, ROW_PREDICT, atcmd_pkg::CODE_REJECT};
    endfunction

    function automatic t_stim_row row_code(input logic [7:0] ch, input logic [2:0] code);
        return '{ch, 5'd1, ROW_GIVES, code};
    endfunction

    function automatic int unsigned draw_gap(input bit burst);
        return burst ? 0 : $urandom_range(0, 11);
    endfunction

    function automatic logic [7:0] any_case(input logic [7:0] c);
        return ($urandom_range(0, 1) == 1) ? (c & 8'hDF) : c;
    endfunction

    function automatic logic [7:0] pick_letter();
        case ($urandom_range(0, 4))
            0: return atcmd_pkg::CH_LH;
            1: return atcmd_pkg::CH_LR;
            2: return atcmd_pkg::CH_LC;
            3: return atcmd_pkg::CH_LS;
            default: return atcmd_pkg::CH_LQ;
        endcase
    endfunction

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 15))
            0: return atcmd_pkg::CH_CR;
            1: return atcmd_pkg::CH_LF;
            2: return atcmd_pkg::CH_BS;
            3: return atcmd_pkg::CH_DEL;
            4: return atcmd_pkg::CH_SPACE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] line_end();
        return ($urandom_range(0, 1) == 1) ? atcmd_pkg::CH_CR : atcmd_pkg::CH_LF;
    endfunction

    // Mostly well-formed command lines; the rest are damaged commands, overlong lines and noise.
    task automatic build_sentence();
        int unsigned pick;
        int unsigned pos;
        pick = $urandom_range(0, 99);
        sentence_q.delete();
        if (pick < 55) begin
            repeat ($urandom_range(0, 3)) sentence_q.push_back(atcmd_pkg::CH_SPACE);
            sentence_q.push_back(any_case(atcmd_pkg::CH_LA));
            sentence_q.push_back(any_case(atcmd_pkg::CH_LT));
            sentence_q.push_back(atcmd_pkg::CH_PLUS);
            if ($urandom_range(0, 9) < 3) begin
                pos = $urandom_range(0, sentence_q.size());
                sentence_q.insert(pos, ($urandom_range(0, 1) == 1) ? atcmd_pkg::CH_BS :
                                                                     atcmd_pkg::CH_DEL);
                sentence_q.insert(pos, 8'($urandom_range(8'h21, 8'h7E)));
            end
            sentence_q.push_back(any_case(pick_letter()));
            if ($urandom_range(0, 2) == 0) sentence_q.push_back(line_end());
        end else if (pick < 70) begin
            sentence_q.push_back(any_case(atcmd_pkg::CH_LA));
            sentence_q.push_back(any_case(atcmd_pkg::CH_LT));
            sentence_q.push_back(atcmd_pkg::CH_PLUS);
            sentence_q.push_back(any_case(pick_letter()));
            pos = $urandom_range(0, 3);
            if ($urandom_range(0, 1) == 1) begin
                sentence_q[pos] = 8'($urandom_range(8'h21, 8'hFF));
            end else begin
                sentence_q.insert(pos, atcmd_pkg::CH_SPACE);
            end
            if (sentence_q.size() > 4) void'(sentence_q.pop_back());
            sentence_q.push_back(line_end());
        end else if (pick < 80) begin
            repeat ($urandom_range(15, 17)) sentence_q.push_back(8'($urandom_range(8'h21, 8'hFF)));
            sentence_q.push_back(line_end());
        end else begin
            repeat ($urandom_range(1, 8)) sentence_q.push_back(noise_byte());
            if ($urandom_range(0, 4) != 0) sentence_q.push_back(line_end());
        end
    endtask

    task automatic send_char(input logic [7:0] c, input t_item_tag tag, input int unsigned gap);
        if (gap > 0) begin
            char_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        char_tag_q.push_back(tag);
        char_ch.valid   <= 1'b1;
        char_ch.char_in <= c;
        do @(posedge i_clk); while (!char_ch.ready);
    endtask

    always @(posedge i_clk) begin : track_p
        t_item_tag  tag;
        bit         gives;
        bit         ignored;
        bit         moved;
        logic [2:0] code;
        logic [2:0] want;
        moved = 1'b0;
        if (i_rst_n && char_ch.valid && char_ch.ready) begin
            moved = 1'b1;
            tag = char_tag_q.pop_front();
            take_char(char_ch.char_in, gives, code, ignored);
            if (!ignored) chars_counted++;
            if (tag.kind == ROW_GIVES) begin
                code_expect_q.push_back(tag.code);
            end else if (tag.kind == ROW_PREDICT && gives) begin
                code_expect_q.push_back(code);
            end
        end
        if (i_rst_n && code_ch.valid && code_ch.ready) begin
            moved = 1'b1;
            if (code_expect_q.size() == 0) begin
                error_count++;
                $display("%0t: command_code expected none, actual %0d", $time,
                         code_ch.command_code);
            end else begin
                want = code_expect_q.pop_front();
                codes_checked++;
                if (want == atcmd_pkg::CODE_REJECT) rejects_checked++;
                if (code_ch.command_code !== want) begin
                    error_count++;
                    $display("%0t: command_code expected %0d, actual %0d", $time, want,
                             code_ch.command_code);
                end
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d codes outstanding", $time,
                     IDLE_LIMIT, code_expect_q.size());
            $display("** at_command_line_recognizer_unit: FAILED **");
            $finish;
        end
    end

    initial begin : drain_p
        int unsigned stall;
        int unsigned taken;
        bit          burst;
        taken = 0;
        burst = 1'b0;
        code_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                code_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                stall = draw_gap(burst);
                if (stall > 0) begin
                    code_ch.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            code_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!code_ch.valid);
            taken++;
            if (taken % 24 == 0) burst = ($urandom_range(0, 3) == 0);
        end
    end

    initial begin : stimulus_p
        int unsigned r;
        int unsigned k;
        bit          burst;
        t_item_tag   tag;
        i_rst_n         <= 1'b0;
        char_ch.valid   <= 1'b0;
        char_ch.char_in <= 8'h00;
        directed_rows = '{
            row_quiet(atcmd_pkg::CH_CR, 1), row_pred(atcmd_pkg::CH_BS),
            row_quiet(atcmd_pkg::CH_DEL, 1), row_quiet(atcmd_pkg::CH_LF, 1),
            row_quiet(8'hFF, 1), row_code(atcmd_pkg::CH_LF, atcmd_pkg::CODE_REJECT),
            row_quiet("a", 1), row_quiet("T", 1), row_quiet("+", 1), row_quiet("x", 1),
            row_quiet(atcmd_pkg::CH_BS, 1), row_code("H", atcmd_pkg::CODE_HELP),
            row_quiet(" ", 1), row_quiet("A", 1), row_quiet("t", 1), row_quiet("+", 1),
            row_code("r", atcmd_pkg::CODE_RUN),
            row_quiet("A", 1), row_quiet("T", 1), row_quiet("+", 1),
            row_code("C", atcmd_pkg::CODE_CHECK),
            row_quiet("a", 1), row_quiet("t", 1), row_quiet("+", 1),
            row_code("s", atcmd_pkg::CODE_SIGN),
            row_quiet(" ", 2), row_quiet("A", 1), row_quiet("T", 1), row_quiet("+", 1),
            row_code("q", atcmd_pkg::CODE_QUIT),
            row_quiet(8'h00, 15), row_code("z", atcmd_pkg::CODE_REJECT),
            row_pred(8'h80), row_pred("A"), row_pred("T"),
            row_code(atcmd_pkg::CH_CR, atcmd_pkg::CODE_REJECT)
        };
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < N_DIRECTED; r++) begin
            burst = ($urandom_range(0, 2) == 0);
            tag = t_item_tag'{directed_rows[r].kind, directed_rows[r].code};
            for (k = 0; k < directed_rows[r].count; k++) begin
                send_char(directed_rows[r].ch, tag, draw_gap(burst));
            end
        end

        hold_req = 1'b1;
        while (chars_counted < ITEM_TARGET) begin
            build_sentence();
            burst = ($urandom_range(0, 3) == 0);
            foreach (sentence_q[k]) begin
                send_char(sentence_q[k], t_item_tag'{ROW_PREDICT, atcmd_pkg::CODE_REJECT},
                          draw_gap(burst));
            end
        end
        char_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (code_expect_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d characters that changed the line and %0d command codes,",
                 chars_counted, codes_checked);
        $display("of which %0d were rejected lines, with a %0d-cycle output hold-off.",
                 rejects_checked, HOLD_CYCLES);
        if (error_count == 0) begin
            $display("** at_command_line_recognizer_unit: PASSED **");
        end else begin
            $display("** at_command_line_recognizer_unit: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
